// ----- sv/imc_pkg.sv -----
// ============================================================================
// IMU turn and motion classifier package
// Shared widths, register indexes, event and state codes, and the structs
// that pass configuration, calibration status and results between modules.
// ============================================================================
package imc_pkg;

    // Calibration length and the settle time of the stop detector.
    localparam int CALIB_SAMPLES = 5;
    localparam int STILL_SETTLE  = 4;

    // Field widths.
    localparam int YAW_W   = 15;
    localparam int ACC_W   = 16;
    localparam int SUM_W   = 19;
    localparam int CNT_W   = 3;
    localparam int THR_W   = 18;

    // Reciprocal for the truncating divide of the calibration sum.
    localparam int CALIB_SHIFT = 22;
    localparam int RECIP_W     = 23;
    localparam int CALIB_RECIP = ((1 << CALIB_SHIFT) + CALIB_SAMPLES - 1) / CALIB_SAMPLES;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int QUOT_W      = ACC_W + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ENTER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_ENTER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HARD_TURN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_MARGIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_TIMEOUT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_CONFIRM  = 3'd7;

    // Turn state codes.
    localparam logic [1:0] TURN_STRAIGHT = 2'd0;
    localparam logic [1:0] TURN_LEFT     = 2'd1;
    localparam logic [1:0] TURN_RIGHT    = 2'd2;

    // Turn event codes.
    localparam logic [2:0] EV_NONE        = 3'd0;
    localparam logic [2:0] EV_LEFT_NORMAL  = 3'd1;
    localparam logic [2:0] EV_LEFT_HARD    = 3'd2;
    localparam logic [2:0] EV_RIGHT_NORMAL = 3'd3;
    localparam logic [2:0] EV_RIGHT_HARD   = 3'd4;

    typedef struct packed {
        logic        [13:0] left_enter;
        logic signed [14:0] right_enter;
        logic        [13:0] band_high;
        logic signed [14:0] band_low;
        logic        [13:0] hard_turn;
        logic        [11:0] move_margin;
        logic        [4:0]  still_timeout;
        logic        [3:0]  stop_confirm;
    } imc_cfg_t;

    typedef struct packed {
        logic                    calibrated;
        logic signed [ACC_W-1:0] rest_offset;
    } imc_calib_t;

    typedef struct packed {
        logic [2:0] turn_event;
        logic       moving;
    } imc_result_t;

endpackage

// ----- sv/imc_ifs.sv -----
// ============================================================================
// IMU classifier stream interfaces
// Valid/ready channels for input samples and for classification results.
// ============================================================================
interface imc_in_if import imc_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [YAW_W-1:0] yaw_angle;
    logic signed [ACC_W-1:0] accel_fwd;

    modport source (output valid, output yaw_angle, output accel_fwd, input ready);
    modport sink   (input valid, input yaw_angle, input accel_fwd, output ready);
endinterface

interface imc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] turn_event;
    logic       moving;

    modport source (output valid, output turn_event, output moving, input ready);
    modport sink   (input valid, input turn_event, input moving, output ready);
endinterface

// ----- sv/imc_cfg_regs.sv -----
// ============================================================================
// IMU classifier configuration registers
// Holds the thresholds and counts written through the plain write port.
// ============================================================================
module imc_cfg_regs import imc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output imc_cfg_t              cfg
);

    imc_cfg_t cfg_reg;

    // Register writes, each truncated to the width of its field.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_enter    <= 14'd512;
            cfg_reg.right_enter   <= -15'sd480;
            cfg_reg.band_high     <= 14'd192;
            cfg_reg.band_low      <= -15'sd192;
            cfg_reg.hard_turn     <= 14'd1600;
            cfg_reg.move_margin   <= 12'd82;
            cfg_reg.still_timeout <= 5'd17;
            cfg_reg.stop_confirm  <= 4'd6;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LEFT_ENTER:    cfg_reg.left_enter    <= cfg_wdata[13:0];
                CFG_RIGHT_ENTER:   cfg_reg.right_enter   <= $signed(cfg_wdata[14:0]);
                CFG_BAND_HIGH:     cfg_reg.band_high     <= cfg_wdata[13:0];
                CFG_BAND_LOW:      cfg_reg.band_low      <= $signed(cfg_wdata[14:0]);
                CFG_HARD_TURN:     cfg_reg.hard_turn     <= cfg_wdata[13:0];
                CFG_MOVE_MARGIN:   cfg_reg.move_margin   <= cfg_wdata[11:0];
                CFG_STILL_TIMEOUT: cfg_reg.still_timeout <= cfg_wdata[4:0];
                CFG_STOP_CONFIRM:  cfg_reg.stop_confirm  <= cfg_wdata[3:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/imc_calib.sv -----
// ============================================================================
// IMU classifier rest calibration
// Sums the first samples' acceleration and stores the truncated average
// as the rest offset.
// ============================================================================
module imc_calib import imc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic signed [ACC_W-1:0] accel,
    output imc_calib_t              calib
);

    logic                    calibrated_reg;
    logic [CNT_W-1:0]        calib_count_reg;
    logic signed [SUM_W-1:0] accel_sum_reg;
    logic signed [ACC_W-1:0] rest_offset_reg;

    logic signed [SUM_W-1:0] sum_total;
    logic [CNT_W:0]          count_inc;
    logic                    calib_done;
    logic                    sum_neg;
    logic [SUM_W-1:0]        sum_mag;
    logic [PROD_W-1:0]       product;
    logic [QUOT_W-1:0]       quot_mag;
    logic [QUOT_W-1:0]       quot_signed;

    // Running sum and sample count including the current item.
    assign sum_total  = accel_sum_reg + {{(SUM_W-ACC_W){accel[ACC_W-1]}}, accel};
    assign count_inc  = {1'b0, calib_count_reg} + (CNT_W+1)'(1);
    assign calib_done = (count_inc >= (CNT_W+1)'(CALIB_SAMPLES));

    // Divide truncating toward zero: divide the magnitude, then restore the sign.
    assign sum_neg     = sum_total[SUM_W-1];
    assign sum_mag     = sum_neg ? $unsigned(-sum_total) : $unsigned(sum_total);
    assign product     = PROD_W'(sum_mag) * PROD_W'(CALIB_RECIP);
    assign quot_mag    = product[CALIB_SHIFT +: QUOT_W];
    assign quot_signed = sum_neg ? (~quot_mag + QUOT_W'(1)) : quot_mag;

    // Accumulate until the calibration length is reached, then latch the offset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calibrated_reg  <= 1'b0;
            calib_count_reg <= '0;
            accel_sum_reg   <= '0;
            rest_offset_reg <= '0;
        end
        else if (step && !calibrated_reg)
        begin
            if (calib_done)
            begin
                rest_offset_reg <= $signed(quot_signed[ACC_W-1:0]);
                accel_sum_reg   <= '0;
                calib_count_reg <= '0;
                calibrated_reg  <= 1'b1;
            end
            else
            begin
                accel_sum_reg   <= sum_total;
                calib_count_reg <= count_inc[CNT_W-1:0];
            end
        end
    end

    assign calib.calibrated  = calibrated_reg;
    assign calib.rest_offset = rest_offset_reg;

endmodule

// ----- sv/imc_classify.sv -----
// ============================================================================
// IMU classifier turn and motion logic
// Turn hysteresis, hard turn reporting, moving flag and stop detector.
// ============================================================================
module imc_classify import imc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  imc_calib_t              calib,
    input  imc_cfg_t                cfg,
    input  logic signed [YAW_W-1:0] yaw,
    input  logic signed [ACC_W-1:0] accel,
    output imc_result_t             result
);

    logic [1:0] turn_state_reg;
    logic [1:0] turn_state_next;
    logic       motion_reg;
    logic       motion_next;
    logic       stopping_reg;
    logic       stopping_next;
    logic [4:0] still_count_reg;
    logic [4:0] still_count_next;
    logic [3:0] stop_count_reg;
    logic [3:0] stop_count_next;

    logic signed [THR_W-1:0] acc_lo;
    logic signed [THR_W-1:0] acc_hi;
    logic signed [THR_W-1:0] acc_x;
    logic signed [YAW_W:0]   yaw_x;
    logic signed [YAW_W:0]   yaw_mag;
    logic signed [YAW_W:0]   hard_x;
    logic                    in_band;
    logic                    quiet;
    logic                    left_hard;
    logic                    right_hard;
    logic [2:0]              event_code;

    // Motion thresholds around the rest offset, formed without saturation.
    assign acc_x  = {{(THR_W-ACC_W){accel[ACC_W-1]}}, accel};
    assign acc_lo = {{(THR_W-ACC_W){calib.rest_offset[ACC_W-1]}}, calib.rest_offset}
                    - $signed({6'b0, cfg.move_margin});
    assign acc_hi = {{(THR_W-ACC_W){calib.rest_offset[ACC_W-1]}}, calib.rest_offset}
                    + $signed({6'b0, cfg.move_margin});
    assign quiet  = (acc_x > acc_lo) && (acc_x < acc_hi);

    // Yaw band and hard turn compares.
    assign in_band    = (yaw < $signed({1'b0, cfg.band_high})) && (yaw > cfg.band_low);
    assign yaw_x      = {yaw[YAW_W-1], yaw};
    assign yaw_mag    = yaw_x[YAW_W] ? -yaw_x : yaw_x;
    assign hard_x     = $signed({2'b0, cfg.hard_turn});
    assign left_hard  = (yaw_mag > hard_x);
    assign right_hard = (yaw_x < -hard_x);

    // Next state of the turn tracker and the stop detector for this item.
    always_comb
    begin
        turn_state_next  = turn_state_reg;
        motion_next      = motion_reg;
        stopping_next    = stopping_reg;
        still_count_next = still_count_reg;
        stop_count_next  = stop_count_reg;
        event_code       = EV_NONE;

        // Turn entry with hysteresis; the straight band wins.
        if (yaw < cfg.right_enter)
        begin
            turn_state_next = TURN_RIGHT;
            motion_next     = 1'b1;
        end
        else if (yaw > $signed({1'b0, cfg.left_enter}))
        begin
            turn_state_next = TURN_LEFT;
            motion_next     = 1'b1;
        end
        if (in_band)
        begin
            turn_state_next = TURN_STRAIGHT;
        end

        case (turn_state_next)
            TURN_LEFT:  event_code = left_hard ? EV_LEFT_HARD : EV_LEFT_NORMAL;
            TURN_RIGHT: event_code = right_hard ? EV_RIGHT_HARD : EV_RIGHT_NORMAL;
            default:    event_code = EV_NONE;
        endcase

        // While straight, acceleration starts motion and braking arms the stop detector.
        if (turn_state_next == TURN_STRAIGHT)
        begin
            if (acc_x < acc_lo)
            begin
                motion_next = 1'b1;
            end
            else if ((acc_x > acc_hi) && motion_next)
            begin
                stopping_next    = 1'b1;
                still_count_next = '0;
                stop_count_next  = '0;
            end
        end

        // Stop window: time out, or count quiet samples after the settle time.
        if (stopping_next)
        begin
            still_count_next = still_count_next + 5'd1;
            if (still_count_next >= cfg.still_timeout)
            begin
                stopping_next    = 1'b0;
                still_count_next = '0;
            end
            if (quiet && in_band && (still_count_next >= 5'(STILL_SETTLE)))
            begin
                stop_count_next = stop_count_next + 4'd1;
                if (stop_count_next >= cfg.stop_confirm)
                begin
                    stopping_next    = 1'b0;
                    stop_count_next  = '0;
                    still_count_next = '0;
                    motion_next      = 1'b0;
                end
            end
        end
    end

    // State advances only for items seen after calibration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_state_reg  <= TURN_STRAIGHT;
            motion_reg      <= 1'b0;
            stopping_reg    <= 1'b0;
            still_count_reg <= '0;
            stop_count_reg  <= '0;
        end
        else if (step && calib.calibrated)
        begin
            turn_state_reg  <= turn_state_next;
            motion_reg      <= motion_next;
            stopping_reg    <= stopping_next;
            still_count_reg <= still_count_next;
            stop_count_reg  <= stop_count_next;
        end
    end

    // During calibration no event is reported and the flag shows the held state.
    assign result.turn_event = calib.calibrated ? event_code : EV_NONE;
    assign result.moving     = calib.calibrated ? motion_next : motion_reg;

endmodule

// ----- sv/imu_turn_motion_classifier.sv -----
// Each sample passes through the sample register and then the result register, where a stalled result waits.
// Throughput: one sample per cycle while results are taken; the sample register and the result
// register let a new sample enter while a finished result waits.
// All work sits between those two registers: compares, one small adder
// chain and the calibration divide, done as one reciprocal multiply.
// Reset restores the default thresholds, clears the state and both pipeline valid bits.
// ============================================================================
// IMU turn and motion classifier
// Classifies yaw into straight, left or right turns and tracks whether the
// vehicle is moving from forward acceleration against a calibrated offset.
// ============================================================================
module imu_turn_motion_classifier import imc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    imc_in_if.sink                samples,
    imc_out_if.source             results,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    imc_cfg_t                cfg;
    imc_calib_t              calib;
    imc_result_t             result;

    logic                    s1_valid_reg;
    logic signed [YAW_W-1:0] s1_yaw_reg;
    logic signed [ACC_W-1:0] s1_accel_reg;
    logic                    out_valid_reg;
    imc_result_t             out_result_reg;

    logic                    out_free;
    logic                    step;
    logic                    in_take;

    // Handshake: the sample register moves on whenever the result register can load.
    assign out_free      = !out_valid_reg || results.ready;
    assign step          = s1_valid_reg && out_free;
    assign samples.ready = !s1_valid_reg || out_free;
    assign in_take       = samples.valid && samples.ready;

    imc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    imc_calib u_calib (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .accel (s1_accel_reg),
        .calib (calib)
    );

    imc_classify u_classify (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .calib  (calib),
        .cfg    (cfg),
        .yaw    (s1_yaw_reg),
        .accel  (s1_accel_reg),
        .result (result)
    );

    // Valid bits of the sample and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the sample and result registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_yaw_reg   <= samples.yaw_angle;
            s1_accel_reg <= samples.accel_fwd;
        end
        if (step)
        begin
            out_result_reg <= result;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.turn_event = out_result_reg.turn_event;
    assign results.moving     = out_result_reg.moving;

endmodule

// ----- sv/imc_checker.sv -----
// ============================================================================
// IMU classifier port checker
// Watches the stream ports of the classifier and flags handshake and
// pipeline ordering errors.
// ============================================================================
module imc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       samples_valid,
    input logic       samples_ready,
    input logic       results_valid,
    input logic       results_ready,
    input logic [2:0] turn_event,
    input logic       moving
);

    // A stalled result item stays offered.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && !results_ready |=> results_valid)
        else $error("result item dropped while stalled");

    // A stalled result item keeps its payload.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && !results_ready |=> $stable(turn_event) && $stable(moving))
        else $error("result payload changed while stalled");

    // A result appearing on an empty output came from an accepted input item.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results_valid) |-> $past(samples_valid && samples_ready, 2))
        else $error("result item without a matching input item");

    // With the output empty the sample register can always drain, so input is open.
    a_input_open: assert property (@(posedge clk) disable iff (!rst_n)
        !results_valid |-> samples_ready)
        else $error("input stalled while output is empty");

endmodule

bind imu_turn_motion_classifier imc_checker u_imc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .samples_valid (samples.valid),
    .samples_ready (samples.ready),
    .results_valid (results.valid),
    .results_ready (results.ready),
    .turn_event    (results.turn_event),
    .moving        (results.moving)
);

// ----- verif/imu_turn_motion_classifier_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// IMU turn and motion classifier testbench
// Drives IMU samples through the valid/ready input channel and checks every
// classification result against an in-bench predictor of the calibration,
// turn hysteresis and stop detection logic. The run covers the reset
// thresholds, several register settings including the extremes, and phases
// of random sender idling and receiver stalls.
// ============================================================================
module imu_turn_motion_classifier_tb;
    import imc_pkg::*;

    localparam int CYCLE_LIMIT       = 200000;
    localparam int NUM_SETTINGS      = 7;
    localparam int ITEMS_PER_SETTING = 150;
    localparam int DRAIN_CYCLES      = 4;
    localparam int YAW_MIN           = -11520;
    localparam int YAW_MAX           = 11520;

    typedef struct {
        logic signed [YAW_W-1:0] yaw;
        logic signed [ACC_W-1:0] acc;
    } imu_sample_t;

    typedef struct {
        int left_enter;
        int right_enter;
        int band_high;
        int band_low;
        int hard_turn;
        int move_margin;
        int still_timeout;
        int stop_confirm;
    } cfg_setting_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    imc_in_if  samples_if ();
    imc_out_if results_if ();

    imu_turn_motion_classifier uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_if),
        .results   (results_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Stimulus and expectation queues.
    imu_sample_t queued_samples [$];
    imc_result_t predicted_classes [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int error_count   = 0;
    int cycle_count   = 0;

    imu_sample_t  next_sample;
    imc_result_t  wanted;
    cfg_setting_t settings [NUM_SETTINGS];
    int idle_plan [4][2] = '{'{0, 0}, '{65, 0}, '{0, 65}, '{18, 18}};

    // Predictor copy of the thresholds and of the classifier state.
    imc_cfg_t                cfg_shadow;
    logic                    calibrated_q = 1'b0;
    logic [CNT_W-1:0]        calib_n      = '0;
    logic signed [SUM_W-1:0] calib_sum    = '0;
    logic signed [ACC_W-1:0] rest_off     = '0;
    logic [1:0]              heading      = TURN_STRAIGHT;
    logic                    moving_q     = 1'b0;
    logic                    stop_armed   = 1'b0;
    logic [4:0]              settle_cnt   = '0;
    logic [3:0]              quiet_cnt    = '0;

    // Works out the result of one accepted sample and advances the state.
    function automatic imc_result_t classify_sample(input logic signed [YAW_W-1:0] yaw_in,
                                                    input logic signed [ACC_W-1:0] acc_in);
        int yaw;
        int acc;
        int lo;
        int hi;
        int mag;
        int hard;
        logic in_band;
        logic quiet;
        imc_result_t res;
        yaw = int'(yaw_in);
        acc = int'(acc_in);
        res.turn_event = EV_NONE;
        if (!calibrated_q) begin
            // Calibration only accumulates; the mean is truncated toward zero.
            calib_n   = calib_n + 3'd1;
            calib_sum = calib_sum + SUM_W'(acc);
            if (calib_n >= CALIB_SAMPLES) begin
                rest_off     = ACC_W'(calib_sum / CALIB_SAMPLES);
                calib_sum    = '0;
                calib_n      = '0;
                calibrated_q = 1'b1;
            end
        end else begin
            lo   = int'(rest_off) - int'(cfg_shadow.move_margin);
            hi   = int'(rest_off) + int'(cfg_shadow.move_margin);
            hard = int'(cfg_shadow.hard_turn);
            in_band = (yaw < int'(cfg_shadow.band_high)) &&
                      (yaw > int'($signed(cfg_shadow.band_low)));
            quiet = (acc > lo) && (acc < hi);

            // Right entry is tested first; the straight band overrides both.
            if (yaw < int'($signed(cfg_shadow.right_enter))) begin
                heading  = TURN_RIGHT;
                moving_q = 1'b1;
            end else if (yaw > int'(cfg_shadow.left_enter)) begin
                heading  = TURN_LEFT;
                moving_q = 1'b1;
            end
            if (in_band)
                heading = TURN_STRAIGHT;

            mag = (yaw < 0) ? -yaw : yaw;
            if (heading == TURN_LEFT)
                res.turn_event = (mag > hard) ? EV_LEFT_HARD : EV_LEFT_NORMAL;
            else if (heading == TURN_RIGHT)
                res.turn_event = (yaw < -hard) ? EV_RIGHT_HARD : EV_RIGHT_NORMAL;

            // Going straight: a push below the offset means moving, a brake
            // above it while moving arms the stop detector.
            if (heading == TURN_STRAIGHT) begin
                if (acc < lo) begin
                    moving_q = 1'b1;
                end else if (acc > hi && moving_q) begin
                    stop_armed = 1'b1;
                    settle_cnt = '0;
                    quiet_cnt  = '0;
                end
            end

            // The window may time out and the quiet test still runs after it.
            if (stop_armed) begin
                settle_cnt = settle_cnt + 5'd1;
                if (settle_cnt >= cfg_shadow.still_timeout) begin
                    stop_armed = 1'b0;
                    settle_cnt = '0;
                end
                if (quiet && in_band && settle_cnt >= STILL_SETTLE) begin
                    quiet_cnt = quiet_cnt + 4'd1;
                    if (quiet_cnt >= cfg_shadow.stop_confirm) begin
                        stop_armed = 1'b0;
                        quiet_cnt  = '0;
                        settle_cnt = '0;
                        moving_q   = 1'b0;
                    end
                end
            end
        end
        res.moving = moving_q;
        return res;
    endfunction

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Yaw strictly inside the straight band, or zero where the band is empty.
    function automatic int band_yaw();
        int l;
        int h;
        l = clamp(int'($signed(cfg_shadow.band_low)) + 1, YAW_MIN, YAW_MAX);
        h = clamp(int'(cfg_shadow.band_high) - 1, YAW_MIN, YAW_MAX);
        if (l > h)
            return 0;
        return l + int'($urandom_range(h - l));
    endfunction

    // Acceleration strictly between the two motion thresholds, or the rest offset if none lies between.
    function automatic int quiet_accel(input int lo, input int hi);
        if (hi - lo < 2)
            return int'(rest_off);
        return lo + 1 + int'($urandom_range(hi - lo - 2));
    endfunction

    // Acceleration that breaks a quiet run: a threshold itself or anything.
    function automatic int noise_accel(input int lo, input int hi);
        case ($urandom_range(2))
            0:       return lo;
            1:       return hi;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    task automatic push_sample(input int yaw, input int acc);
        imu_sample_t s;
        s.yaw = YAW_W'(clamp(yaw, YAW_MIN, YAW_MAX));
        s.acc = ACC_W'(clamp(acc, -32768, 32767));
        queued_samples.push_back(s);
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Queues random items, mostly stop and turn sequences shaped by the
    // current thresholds, the rest edge values and plain noise.
    task automatic queue_random_items(input int count);
        int queued;
        int n;
        int lo;
        int hi;
        int yaw;
        int lefti;
        int righti;
        int bh;
        int bl;
        int hard;
        int kind;
        logic dir;
        queued = 0;
        while (queued < count) begin
            lo     = int'(rest_off) - int'(cfg_shadow.move_margin);
            hi     = int'(rest_off) + int'(cfg_shadow.move_margin);
            lefti  = int'(cfg_shadow.left_enter);
            righti = int'($signed(cfg_shadow.right_enter));
            bh     = int'(cfg_shadow.band_high);
            bl     = int'($signed(cfg_shadow.band_low));
            hard   = int'(cfg_shadow.hard_turn);
            kind   = $urandom_range(9);
            if (kind <= 3) begin
                // Speed up, brake, then a run of mostly quiet samples.
                push_sample(band_yaw(), lo - 1 - int'($urandom_range(300)));
                push_sample(band_yaw(), hi + 1 + int'($urandom_range(300)));
                n = $urandom_range(24);
                for (int i = 0; i < n; i++)
                    push_sample(band_yaw(), ($urandom_range(9) == 0) ?
                                noise_accel(lo, hi) : quiet_accel(lo, hi));
                queued += n + 2;
            end else if (kind <= 5) begin
                // A turn one way, around the hard threshold, then back.
                dir = 1'($urandom_range(1));
                n = 2 + $urandom_range(10);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(3))
                        0: yaw = dir ? lefti + 1 + int'($urandom_range(400))
                                     : righti - 1 - int'($urandom_range(400));
                        1: yaw = dir ? hard - 2 + int'($urandom_range(4))
                                     : -hard - 2 + int'($urandom_range(4));
                        2: yaw = dir ? bh + int'($urandom_range(lefti > bh ? lefti - bh : 0))
                                     : bl - int'($urandom_range(bl > righti ? bl - righti : 0));
                        default: yaw = dir ? YAW_MAX : YAW_MIN;
                    endcase
                    push_sample(yaw, $urandom_range(1) ? quiet_accel(lo, hi)
                                                       : noise_accel(lo, hi));
                end
                push_sample(band_yaw(), quiet_accel(lo, hi));
                queued += n + 1;
            end else if (kind == 6) begin
                // Yaw and acceleration on or next to a threshold.
                case ($urandom_range(11))
                    0:  yaw = lefti;
                    1:  yaw = lefti + 1;
                    2:  yaw = righti;
                    3:  yaw = righti - 1;
                    4:  yaw = bh;
                    5:  yaw = bh - 1;
                    6:  yaw = bl;
                    7:  yaw = bl + 1;
                    8:  yaw = hard;
                    9:  yaw = hard + 1;
                    10: yaw = -hard;
                    default: yaw = -hard - 1;
                endcase
                push_sample(yaw, ($urandom_range(1) ? lo : hi) - 1 + int'($urandom_range(2)));
                queued++;
            end else begin
                push_sample(YAW_MIN + int'($urandom_range(YAW_MAX - YAW_MIN)),
                            $urandom_range(1) ? int'($signed(16'($urandom)))
                                : lo - 50 + int'($urandom_range(hi - lo + 100)));
                queued++;
            end
        end
    endtask

    // Waits until every queued item is accepted and every result is back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (queued_samples.size() != 0 || samples_if.valid ||
               predicted_classes.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        case (idx)
            CFG_LEFT_ENTER:    cfg_shadow.left_enter    = 14'(value);
            CFG_RIGHT_ENTER:   cfg_shadow.right_enter   = 15'(value);
            CFG_BAND_HIGH:     cfg_shadow.band_high     = 14'(value);
            CFG_BAND_LOW:      cfg_shadow.band_low      = 15'(value);
            CFG_HARD_TURN:     cfg_shadow.hard_turn     = 14'(value);
            CFG_MOVE_MARGIN:   cfg_shadow.move_margin   = 12'(value);
            CFG_STILL_TIMEOUT: cfg_shadow.still_timeout = 5'(value);
            CFG_STOP_CONFIRM:  cfg_shadow.stop_confirm  = 4'(value);
            default: ;
        endcase
    endtask

    task automatic apply_setting(input cfg_setting_t s);
        cfg_write(CFG_LEFT_ENTER, s.left_enter);
        cfg_write(CFG_RIGHT_ENTER, s.right_enter);
        cfg_write(CFG_BAND_HIGH, s.band_high);
        cfg_write(CFG_BAND_LOW, s.band_low);
        cfg_write(CFG_HARD_TURN, s.hard_turn);
        cfg_write(CFG_MOVE_MARGIN, s.move_margin);
        cfg_write(CFG_STILL_TIMEOUT, s.still_timeout);
        cfg_write(CFG_STOP_CONFIRM, s.stop_confirm);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sender: offers the next queued item, or idles at the phase's rate.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            samples_if.valid <= 1'b0;
        end else if (!samples_if.valid || samples_if.ready) begin
            if (queued_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_sample = queued_samples.pop_front();
                samples_if.valid     <= 1'b1;
                samples_if.yaw_angle <= next_sample.yaw;
                samples_if.accel_fwd <= next_sample.acc;
            end else begin
                samples_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls at the phase's rate.
    always @(posedge clk)
    begin
        if (!rst_n)
            results_if.ready <= 1'b0;
        else
            results_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Each accepted item is predicted at the edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n && samples_if.valid && samples_if.ready)
            predicted_classes.push_back(classify_sample(samples_if.yaw_angle,
                                                        samples_if.accel_fwd));
    end

    // Each accepted result is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready) begin
            if (predicted_classes.size() == 0) begin
                report_mismatch($sformatf("result event %0d moving %0b with no item pending",
                                          results_if.turn_event, results_if.moving));
            end else begin
                wanted = predicted_classes.pop_front();
                if (results_if.turn_event !== wanted.turn_event)
                    report_mismatch($sformatf("turn_event got %0d want %0d",
                                              results_if.turn_event, wanted.turn_event));
                if (results_if.moving !== wanted.moving)
                    report_mismatch($sformatf("moving got %0b want %0b",
                                              results_if.moving, wanted.moving));
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("imu_turn_motion_classifier_tb failed");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        samples_if.valid     = 1'b0;
        samples_if.yaw_angle = '0;
        samples_if.accel_fwd = '0;
        results_if.ready     = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_LEFT_ENTER;
        cfg_wdata            = '0;
        rst_n                = 1'b0;

        cfg_shadow.left_enter    = 14'd512;
        cfg_shadow.right_enter   = -15'sd480;
        cfg_shadow.band_high     = 14'd192;
        cfg_shadow.band_low      = -15'sd192;
        cfg_shadow.hard_turn     = 14'd1600;
        cfg_shadow.move_margin   = 12'd82;
        cfg_shadow.still_timeout = 5'd17;
        cfg_shadow.stop_confirm  = 4'd6;

        // Reset values, low and high extremes, mid values, a right threshold
        // above the left one with a zero timeout, a zero stop confirm, and values beyond range.
        settings = '{
            '{512, -480, 192, -192, 1600, 82, 17, 6},
            '{0, 0, 0, 0, 0, 0, 1, 1},
            '{11520, -11520, 11520, -11520, 11520, 4095, 31, 15},
            '{300, -300, 100, -100, 900, 20, 8, 3},
            '{100, 5000, 50, -50, 400, 40, 0, 2},
            '{64, -64, 32, -32, 5000, 300, 12, 0},
            '{16383, -16384, 16383, -16384, 16383, 10, 31, 4}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Calibration on extreme values; the sum of -7 truncates to -1.
        push_sample(11520, 32767);
        push_sample(-11520, -32768);
        push_sample(8191, 3);
        push_sample(-8192, -5);
        push_sample(0, -4);
        // Reset thresholds: margin band is -83..81 around the offset.
        push_sample(0, -84);
        push_sample(513, 0);
        push_sample(1601, 0);
        push_sample(300, 0);
        push_sample(-1600, 0);
        push_sample(-1601, 0);
        push_sample(-300, 0);
        push_sample(-11520, 32767);
        push_sample(191, 0);
        push_sample(0, 82);
        // Quiet run that confirms the stop on its last sample.
        for (int i = 0; i < 8; i++)
            push_sample(0, 0);
        // Band and margin edges are both exclusive.
        push_sample(-192, -83);
        push_sample(11520, -32768);
        wait_drained();

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            send_idle_pct = idle_plan[p % 4][0];
            stall_pct     = idle_plan[p % 4][1];
            apply_setting(settings[p]);
            queue_random_items(ITEMS_PER_SETTING / 2);
            // The sender holds off here until every result is back.
            wait_drained();
            queue_random_items(ITEMS_PER_SETTING - ITEMS_PER_SETTING / 2);
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("imu_turn_motion_classifier_tb passed");
        else
            $display("imu_turn_motion_classifier_tb failed");
        $finish;
    end

endmodule

// ----- files.f -----
sv/imc_pkg.sv
sv/imc_ifs.sv
sv/imc_cfg_regs.sv
sv/imc_calib.sv
sv/imc_classify.sv
sv/imu_turn_motion_classifier.sv
sv/imc_checker.sv
verif/imu_turn_motion_classifier_tb.sv
